### rtl/json_string_unescape_unit_assert.svh
// Assertion macros for the JSON string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] UTF_CNT = 8'h80;
    localparam logic [7:0] UTF_2B  = 8'hC0;
    localparam logic [7:0] UTF_3B  = 8'hE0;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // One classified input byte: up to four output bytes, cnt of them valid.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } cmd_t;

endpackage

### rtl/jsu_front.sv
// Front end: parse state machine that turns each input byte into an output command.
module jsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  jsu_pkg::in_item_t item,
    output logic              push,
    output jsu_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  dc_reg, dc_next;
    logic [11:0] code_reg, code_next;
    logic [2:0][7:0] held_reg;
    logic        held_we;

    logic [7:0]  c;
    logic        fin;
    logic        hex_ok;
    logic [7:0]  hex_tmp;
    logic [3:0]  hex_val;
    logic [15:0] v;

    always_comb
    begin
        c   = item.char_in;
        fin = item.is_final;

        hex_ok  = 1'b1;
        hex_tmp = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            hex_tmp = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            hex_tmp = c - 8'h37;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            hex_tmp = c - 8'h57;
        end
        else
        begin
            hex_ok = 1'b0;
        end
        hex_val = hex_tmp[3:0];
        v       = {code_reg, hex_val};

        mode_next = mode_reg;
        dc_next   = dc_reg;
        code_next = code_reg;
        held_we   = 1'b0;
        cmd.cnt   = 3'd0;
        cmd.bytes = '0;

        case (mode_reg)
            MODE_ESC:
            begin
                mode_next    = MODE_TEXT;
                cmd.cnt      = 3'd1;
                cmd.bytes[0] = c;
                case (c)
                    8'h6E: cmd.bytes[0] = 8'h0A;
                    8'h72: cmd.bytes[0] = 8'h0D;
                    8'h74: cmd.bytes[0] = 8'h09;
                    8'h75:
                    begin
                        cmd.cnt = 3'd0;
                        if (!fin)
                        begin
                            mode_next = MODE_HEX;
                            dc_next   = 2'd0;
                            code_next = 12'h000;
                        end
                    end
                    default: cmd.bytes[0] = c;
                endcase
            end
            MODE_HEX:
            begin
                if (hex_ok && dc_reg == 2'd3)
                begin
                    // Fourth digit: encode the code point as UTF-8.
                    if (v < 16'h0080)
                    begin
                        cmd.cnt      = 3'd1;
                        cmd.bytes[0] = v[7:0];
                    end
                    else if (v < 16'h0800)
                    begin
                        cmd.cnt      = 3'd2;
                        cmd.bytes[0] = jsu_pkg::UTF_2B | {3'b000, v[10:6]};
                        cmd.bytes[1] = jsu_pkg::UTF_CNT | {2'b00, v[5:0]};
                    end
                    else
                    begin
                        cmd.cnt      = 3'd3;
                        cmd.bytes[0] = jsu_pkg::UTF_3B | {4'h0, v[15:12]};
                        cmd.bytes[1] = jsu_pkg::UTF_CNT | {2'b00, v[11:6]};
                        cmd.bytes[2] = jsu_pkg::UTF_CNT | {2'b00, v[5:0]};
                    end
                    dc_next   = 2'd0;
                    code_next = 12'h000;
                    mode_next = MODE_TEXT;
                end
                else if (hex_ok && !fin)
                begin
                    held_we   = 1'b1;
                    code_next = {code_reg[7:0], hex_val};
                    dc_next   = dc_reg + 2'd1;
                end
                else
                begin
                    // Broken escape: flush held digits, then treat c as text.
                    cmd.bytes[0]      = held_reg[0];
                    cmd.bytes[1]      = held_reg[1];
                    cmd.bytes[2]      = held_reg[2];
                    cmd.bytes[dc_reg] = c;
                    dc_next           = 2'd0;
                    code_next         = 12'h000;
                    if (c == jsu_pkg::CH_BSL && !fin)
                    begin
                        mode_next = MODE_ESC;
                        cmd.cnt   = {1'b0, dc_reg};
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        cmd.cnt   = {1'b0, dc_reg} + 3'd1;
                    end
                end
            end
            default:
            begin
                if (c == jsu_pkg::CH_BSL && !fin)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    mode_next    = MODE_TEXT;
                    cmd.cnt      = 3'd1;
                    cmd.bytes[0] = c;
                end
            end
        endcase

        push = accept && (cmd.cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            dc_reg   <= 2'd0;
            code_reg <= 12'h000;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            dc_reg   <= dc_next;
            code_reg <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[dc_reg] <= c;
        end
    end

endmodule

### rtl/jsu_queue.sv
// Command queue between the front end and the byte emitter.
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output jsu_pkg::cmd_t head,
    output logic          nonempty,
    output logic          full
);

    jsu_pkg::cmd_t store [jsu_pkg::Q_DEPTH];

    logic [jsu_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::Q_CNT_W-1:0] count_reg;

    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == jsu_pkg::Q_CNT_W'(jsu_pkg::Q_DEPTH));
    assign head     = store[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/jsu_back.sv
// Back end: walks the head command one byte per beat into the output register.
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::cmd_t      head,
    input  logic               nonempty,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output jsu_pkg::out_item_t result
);

    logic [1:0]         idx_reg;
    logic               valid_reg;
    jsu_pkg::out_item_t result_reg;
    logic               load;
    logic               last;

    assign load = nonempty && (!valid_reg || result_ready);
    assign last = (({1'b0, idx_reg} + 3'd1) == head.cnt);
    assign pop  = load && last;

    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.out_byte <= head.bytes[idx_reg];
            result_reg.run_last <= last;
        end
    end

endmodule

### rtl/json_string_unescape_unit.sv
// A byte that yields output is pushed into the command queue on acceptance, and its first
// result beat is then loaded into the output register. Throughput: one input byte per cycle
// while the 4-entry command queue has room; the output port drains one byte per cycle while
// result_ready is high, so a unicode escape (up to 3 bytes) or a flushed escape (up to 4
// bytes) holds the queue head until all its output bytes are sent. Reset (rst_n low, async):
// parse mode to plain text, digit count, code and queue cleared, no result valid.
module json_string_unescape_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  jsu_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output jsu_pkg::out_item_t result
);

    logic          accept;
    logic          push;
    jsu_pkg::cmd_t push_cmd;
    logic          pop;
    jsu_pkg::cmd_t head;
    logic          nonempty;
    logic          full;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .cmd    (push_cmd)
    );

    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .full     (full)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .nonempty     (nonempty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/jsu_checker.sv
// Port-level checker for the JSON string unescape unit, bound to the top level.
`include "json_string_unescape_unit_assert.svh"

module jsu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input jsu_pkg::out_item_t result
);

    logic [7:0] ob;
    logic       ob_hex;
    logic       stalled;
    logic       mid_beat;

    assign ob       = result.out_byte;
    assign ob_hex   = (ob >= 8'h30 && ob <= 8'h39) || (ob >= 8'h41 && ob <= 8'h46)
                      || (ob >= 8'h61 && ob <= 8'h66);
    assign stalled  = result_valid && !result_ready;
    assign mid_beat = result_valid && !result.run_last;

    `JSU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !result_valid, "result valid during reset")
    `JSU_ASSERT(a_hold, stalled |=> result_valid && $stable(result), "stalled beat changed")
    `JSU_ASSERT(a_full_drains, !item_ready |-> result_valid, "input stalled with no beat offered")
    `JSU_ASSERT(a_mid_byte, mid_beat |-> ob[7] || ob_hex, "non-last beat not UTF-8 nor a digit")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### tb/tb_json_string_unescape_unit.sv
// Self-checking testbench for the streaming JSON string unescape unit.
`timescale 1ns / 1ps

module tb_json_string_unescape_unit;

    localparam int          STALL_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 16;
    localparam int          RANDOM_ITEMS = 470;
    localparam int          DRAIN_EVERY = 150;
    localparam int          MAX_REPORTS = 10;

    localparam logic [7:0]  CH_LC_N = 8'h6E;
    localparam logic [7:0]  CH_LC_R = 8'h72;
    localparam logic [7:0]  CH_LC_T = 8'h74;
    localparam logic [7:0]  CH_LC_U = 8'h75;
    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_SLASH = 8'h2F;
    localparam logic [7:0]  CH_LF = 8'h0A;
    localparam logic [7:0]  CH_CR = 8'h0D;
    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [15:0] CP_ONE_BYTE_END = 16'h0080;
    localparam logic [15:0] CP_TWO_BYTE_END = 16'h0800;

    typedef enum logic [1:0] {PM_TEXT, PM_ESCAPE, PM_HEX} parse_mode_t;

    class unescape_scoreboard;
        parse_mode_t        mode;
        logic [2:0]         digit_cnt;
        logic [7:0]         held [3];
        logic [15:0]        code;
        logic [7:0]         staged [$];
        jsu_pkg::out_item_t expected_bytes [$];
        int                 mismatches;
        int                 in_count;
        int                 out_count;
        int                 broken_count;
        int                 utf_len [4];

        function new();
            mode = PM_TEXT;
            digit_cnt = '0;
            code = '0;
            mismatches = 0;
            in_count = 0;
            out_count = 0;
            broken_count = 0;
            foreach (utf_len[i]) utf_len[i] = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
            if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
            return -1;
        endfunction

        // Append one byte to the results of the current input byte.
        function void stage(logic [7:0] b);
            staged.insert(staged.size(), b);
        endfunction

        // A backslash opens an escape unless it closes the string.
        function void plain_byte(logic [7:0] c, logic fin);
            if (c == jsu_pkg::CH_BSL && !fin) begin
                mode = PM_ESCAPE;
            end
            else begin
                mode = PM_TEXT;
                stage(c);
            end
        endfunction

        function void note_byte(jsu_pkg::in_item_t it);
            logic [7:0]         c;
            logic               fin;
            int                 h;
            logic [15:0]        v;
            jsu_pkg::out_item_t o;
            c = it.char_in;
            fin = it.is_final;
            h = hex_value(c);
            staged.delete();
            in_count++;
            case (mode)
                PM_ESCAPE:
                begin
                    mode = PM_TEXT;
                    case (c)
                        CH_LC_N: stage(CH_LF);
                        CH_LC_R: stage(CH_CR);
                        CH_LC_T: stage(CH_TAB);
                        CH_LC_U:
                        begin
                            if (!fin) begin
                                mode = PM_HEX;
                                digit_cnt = '0;
                                code = '0;
                            end
                        end
                        default: stage(c);
                    endcase
                end
                PM_HEX:
                begin
                    if (h >= 0 && digit_cnt >= 3) begin
                        v = {code[11:0], h[3:0]};
                        if (v < CP_ONE_BYTE_END) begin
                            stage(v[7:0]);
                            utf_len[1]++;
                        end
                        else if (v < CP_TWO_BYTE_END) begin
                            stage(jsu_pkg::UTF_2B | {3'b000, v[10:6]});
                            stage(jsu_pkg::UTF_CNT | {2'b00, v[5:0]});
                            utf_len[2]++;
                        end
                        else begin
                            stage(jsu_pkg::UTF_3B | {4'b0000, v[15:12]});
                            stage(jsu_pkg::UTF_CNT | {2'b00, v[11:6]});
                            stage(jsu_pkg::UTF_CNT | {2'b00, v[5:0]});
                            utf_len[3]++;
                        end
                        digit_cnt = '0;
                        code = '0;
                        mode = PM_TEXT;
                    end
                    else if (h >= 0 && !fin) begin
                        held[digit_cnt] = c;
                        code = {code[11:0], h[3:0]};
                        digit_cnt++;
                    end
                    else begin
                        // Broken escape: release the held digits, then treat the byte as text.
                        for (int k = 0; k < digit_cnt; k++) stage(held[k]);
                        digit_cnt = '0;
                        code = '0;
                        broken_count++;
                        plain_byte(c, fin);
                    end
                end
                default: plain_byte(c, fin);
            endcase
            foreach (staged[i]) begin
                o.out_byte = staged[i];
                o.run_last = (i == staged.size() - 1);
                expected_bytes.insert(expected_bytes.size(), o);
            end
        endfunction

        function void check_byte(jsu_pkg::out_item_t r);
            jsu_pkg::out_item_t want;
            out_count++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat byte=%02h last=%0b",
                             $realtime, r.out_byte, r.run_last);
                return;
            end
            want = expected_bytes.pop_front();
            if (r.out_byte !== want.out_byte || r.run_last !== want.run_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch byte exp=%02h got=%02h, last exp=%0b got=%0b",
                             $realtime, want.out_byte, r.out_byte, want.run_last, r.run_last);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    jsu_pkg::in_item_t  item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    jsu_pkg::out_item_t result;

    unescape_scoreboard sb;
    int        burst_left = 0;
    int        string_count = 0;
    int        stall_cycles = 0;
    int        rdy_mode = 0;
    int        rdy_left = 0;

    json_string_unescape_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: switch between always ready, coin flips, a fixed pattern and a stretch that ends in a full stall.
    always @(posedge clk)
    begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(3, 80);
        end
        else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= (rdy_left % 3 != 0);
            default: result_ready <= (rdy_left > 20);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_byte(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
            stall_cycles = 0;
        end
        else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Send one byte; open a new burst after a random gap when the current one is spent.
    task automatic push_input(logic [7:0] c, logic fin);
        jsu_pkg::in_item_t b;
        int                gap;
        b.char_in = c;
        b.is_final = fin;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= b;
        do @(posedge clk); while (!item_ready);
        sb.note_byte(b);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] d, bit upper);
        if (d < 10) return 8'h30 + d;
        return (upper ? 8'h41 : 8'h61) + d - 8'd10;
    endfunction

    task automatic send_random_string();
        logic [7:0]  s [$];
        logic [15:0] cp;
        logic [7:0]  c;
        int          kind;
        int          ndig;
        int          cut;
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
            else if (kind < 50) begin
                s.insert(s.size(), jsu_pkg::CH_BSL);
                case ($urandom_range(0, 5))
                    0: s.insert(s.size(), CH_LC_N);
                    1: s.insert(s.size(), CH_LC_R);
                    2: s.insert(s.size(), CH_LC_T);
                    3: s.insert(s.size(), CH_QUOTE);
                    4: s.insert(s.size(), jsu_pkg::CH_BSL);
                    default: s.insert(s.size(), CH_SLASH);
                endcase
            end
            else if (kind < 58) begin
                s.insert(s.size(), jsu_pkg::CH_BSL);
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
            else if (kind < 88) begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(0, 16'hFFFF));
                endcase
                s.insert(s.size(), jsu_pkg::CH_BSL);
                s.insert(s.size(), CH_LC_U);
                for (int k = 3; k >= 0; k--)
                    s.insert(s.size(), hex_char(cp[k*4 +: 4], 1'($urandom_range(0, 1))));
            end
            else begin
                ndig = $urandom_range(0, 3);
                s.insert(s.size(), jsu_pkg::CH_BSL);
                s.insert(s.size(), CH_LC_U);
                repeat (ndig)
                    s.insert(s.size(), hex_char(4'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1))));
                do c = 8'($urandom_range(0, 255));
                while (sb.hex_value(c) >= 0);
                if ($urandom_range(0, 3) == 0) c = jsu_pkg::CH_BSL;
                s.insert(s.size(), c);
            end
        end
        // Now and then cut the string short at a random point, which can end it in the middle of an escape.
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, s.size());
            while (s.size() > cut) void'(s.pop_back());
        end
        foreach (s[i])
            push_input(s[i], (i == s.size() - 1) || ($urandom_range(0, 63) == 0));
        string_count++;
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, an escape, three-byte unicode with mixed case,
        // broken escapes, a string ending in a hex digit, trailing u and backslash.
        push_input(8'h00, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_N, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_U, 1'b0);
        push_input(8'h46, 1'b0);   push_input(8'h66, 1'b0);
        push_input(8'h46, 1'b0);   push_input(8'h46, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_U, 1'b0);
        push_input(8'h31, 1'b0);   push_input(8'h32, 1'b0);   push_input(8'h67, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_U, 1'b0);
        push_input(8'h61, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_T, 1'b0);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_U, 1'b0);
        push_input(8'h37, 1'b1);
        push_input(jsu_pkg::CH_BSL, 1'b0);  push_input(CH_LC_U, 1'b1);
        push_input(jsu_pkg::CH_BSL, 1'b1);
        push_input(8'hFF, 1'b1);
        drain_results();

        while (sb.in_count < RANDOM_ITEMS) begin
            send_random_string();
            if (sb.in_count / DRAIN_EVERY != (sb.in_count - 1) / DRAIN_EVERY)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input bytes in %0d strings, %0d result beats checked",
                 sb.in_count, string_count, sb.out_count);
        $display("Unicode escapes of 1/2/3 bytes: %0d/%0d/%0d, broken escapes: %0d",
                 sb.utf_len[1], sb.utf_len[2], sb.utf_len[3], sb.broken_count);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("Mismatches: %0d, results still owed: %0d", sb.mismatches, sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
